@@ rtl/fasr_pkg.sv @@
// Shared types and constants for the fraction add/subtract/reduce unit.
package fasr_pkg;

  // Default operand width
  localparam int IN_WIDTH_DEF = 16;

  // Field widths fixed by the interface
  localparam int REQ_W       = 2;
  localparam int NUM_OUT_W   = 32;
  localparam int DEN_OUT_W   = 31;
  localparam int OUT_TDATA_W = 1 + NUM_OUT_W + DEN_OUT_W;
  localparam int OUT_TUSER_W = 2;

  // Operation codes; the unused code behaves as reduce
  localparam logic [REQ_W-1:0] OP_REDUCE = 2'd0;
  localparam logic [REQ_W-1:0] OP_ADD    = 2'd1;
  localparam logic [REQ_W-1:0] OP_SUB    = 2'd2;

  // Which product the serial multiplier is forming
  typedef enum logic [1:0] {
    SEL_P,   // n1 * d2
    SEL_Q,   // n2 * d1
    SEL_D    // d1 * d2
  } mul_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     take_first;
    logic     mul_start;
    logic     mul_step;
    mul_sel_t mul_sel;
    logic     sum;
    logic     gcd_init;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    logic     out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_addsub;
    logic den_err;
    logic num_zero;
    logic mul_last;
    logic gcd_done;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/fasr_ctrl.sv @@
// Sequencing state machine for the fraction add/subtract/reduce unit.
module fasr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  fasr_pkg::dp_sts_t sts,
  output fasr_pkg::dp_cmd_t cmd
);
  import fasr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MSTART,
    S_MUL,
    S_SUM,
    S_ZCHK,
    S_GCD,
    S_DIV,
    S_FINISH
  } state_t;

  state_t   state_r, state_nxt;
  mul_sel_t sel_r, sel_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.mul_sel = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.den_err) begin
          state_nxt = S_FINISH;
        end else if (sts.is_addsub) begin
          sel_nxt   = SEL_P;
          state_nxt = S_MSTART;
        end else begin
          cmd.take_first = 1'b1;
          state_nxt      = S_ZCHK;
        end
      end
      S_MSTART: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          if (sel_r == SEL_D) begin
            state_nxt = S_SUM;
          end else begin
            sel_nxt   = (sel_r == SEL_P) ? SEL_Q : SEL_D;
            state_nxt = S_MSTART;
          end
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_ZCHK;
      end
      S_ZCHK: begin
        if (sts.num_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.gcd_init = 1'b1;
          state_nxt    = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= SEL_P;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

@@ rtl/fasr_dp.sv @@
// Datapath: operand capture, serial multiplier, binary GCD, dividers, result register.
module fasr_dp #(
  parameter int IN_WIDTH = fasr_pkg::IN_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fasr_pkg::dp_cmd_t                cmd,
  output fasr_pkg::dp_sts_t                sts,
  input  logic [fasr_pkg::REQ_W-1:0]       req_type,
  input  logic signed [IN_WIDTH-1:0]       first_num,
  input  logic signed [IN_WIDTH-1:0]       first_den,
  input  logic signed [IN_WIDTH-1:0]       second_num,
  input  logic signed [IN_WIDTH-1:0]       second_den,
  output logic                             is_negative,
  output logic [fasr_pkg::NUM_OUT_W-1:0]   num_magnitude,
  output logic [fasr_pkg::DEN_OUT_W-1:0]   den_value,
  output logic                             is_zero,
  output logic                             den_error,
  output logic                             out_tvalid,
  input  logic                             out_tready
);
  import fasr_pkg::*;

  localparam int W    = IN_WIDTH;
  localparam int PW   = 2 * W - 1;   // product magnitude
  localparam int WW   = 2 * W;       // sum magnitude
  localparam int SC_W = $clog2(WW);

  function automatic logic [W-1:0] to_mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // Operands in sign-magnitude form
  logic [REQ_W-1:0] op_r;
  logic             n1_neg_r, d1_neg_r, n2_neg_r, d2_neg_r;
  logic [W-1:0]     n1_mag_r, d1_mag_r, n2_mag_r, d2_mag_r;

  // Multiplier
  logic [PW-1:0]    mc_r, acc_r, acc_add, p_r, q_r;
  logic [W-1:0]     mp_r, mul_a, mul_b;
  logic [SC_W-1:0]  sc_r;

  // Fraction before reduction
  logic [WW-1:0]    num_r, den_r;
  logic             num_neg_r, den_neg_r;

  // Sum of cross products
  logic             p_neg, q_neg, is_addsub;
  logic [WW-1:0]    pe, qe, sum_mag;
  logic [WW:0]      diff;
  logic             sum_neg;

  // GCD
  logic [WW-1:0]    ga_r, gb_r;
  logic [SC_W-1:0]  gk_r;

  // Dividers sharing one divisor
  logic [WW-1:0]    dv_r, qn_r, rn_r, qd_r, rd_r;
  logic [WW:0]      tn, td, tn_sub, td_sub;
  logic             gen, ged;

  // Result register
  logic             o_valid_r;
  logic             o_neg_r, o_zero_r, o_err_r;
  logic [NUM_OUT_W-1:0] o_num_r;
  logic [DEN_OUT_W-1:0] o_den_r;

  assign is_addsub = (op_r == OP_ADD) || (op_r == OP_SUB);
  assign p_neg     = n1_neg_r ^ d2_neg_r;
  assign q_neg     = n2_neg_r ^ d1_neg_r ^ (op_r == OP_SUB);

  // Status
  always_comb begin
    sts           = '0;
    sts.is_addsub = is_addsub;
    sts.den_err   = is_addsub ? ((d1_mag_r == '0) || (d2_mag_r == '0))
                              : (d1_mag_r == '0);
    sts.num_zero  = (num_r == '0);
    sts.mul_last  = (sc_r == SC_W'(W - 1));
    sts.gcd_done  = (ga_r == '0) || (gb_r == '0);
    sts.div_last  = (sc_r == SC_W'(WW - 1));
    sts.out_free  = !o_valid_r || out_tready;
  end

  // Multiplier operand select and add
  always_comb begin
    case (cmd.mul_sel)
      SEL_P:   begin mul_a = n1_mag_r; mul_b = d2_mag_r; end
      SEL_Q:   begin mul_a = n2_mag_r; mul_b = d1_mag_r; end
      default: begin mul_a = d1_mag_r; mul_b = d2_mag_r; end
    endcase
    acc_add = mp_r[0] ? (acc_r + mc_r) : acc_r;
  end

  // Signed sum of the cross products
  always_comb begin
    pe   = WW'(p_r);
    qe   = WW'(q_r);
    diff = {1'b0, pe} - {1'b0, qe};
    if (p_neg == q_neg) begin
      sum_mag = pe + qe;
      sum_neg = p_neg;
    end else if (!diff[WW]) begin
      sum_mag = diff[WW-1:0];
      sum_neg = p_neg;
    end else begin
      sum_mag = qe - pe;
      sum_neg = q_neg;
    end
  end

  // Restoring division step for both quotients
  always_comb begin
    tn     = {rn_r, qn_r[WW-1]};
    td     = {rd_r, qd_r[WW-1]};
    tn_sub = tn - {1'b0, dv_r};
    td_sub = td - {1'b0, dv_r};
    gen    = (tn >= {1'b0, dv_r});
    ged    = (td >= {1'b0, dv_r});
  end

  // Arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= req_type;
      n1_neg_r <= first_num[W-1];
      d1_neg_r <= first_den[W-1];
      n2_neg_r <= second_num[W-1];
      d2_neg_r <= second_den[W-1];
      n1_mag_r <= to_mag($unsigned(first_num));
      d1_mag_r <= to_mag($unsigned(first_den));
      n2_mag_r <= to_mag($unsigned(second_num));
      d2_mag_r <= to_mag($unsigned(second_den));
    end

    if (cmd.mul_start) begin
      mc_r  <= PW'(mul_a);
      mp_r  <= mul_b;
      acc_r <= '0;
      sc_r  <= '0;
    end else if (cmd.mul_step) begin
      acc_r <= acc_add;
      mc_r  <= mc_r << 1;
      mp_r  <= mp_r >> 1;
      sc_r  <= sc_r + 1'b1;
      if (sts.mul_last) begin
        case (cmd.mul_sel)
          SEL_P:   p_r   <= acc_add;
          SEL_Q:   q_r   <= acc_add;
          default: den_r <= WW'(acc_add);
        endcase
      end
    end else if (cmd.div_init) begin
      sc_r <= '0;
    end else if (cmd.div_step) begin
      sc_r <= sc_r + 1'b1;
    end

    // Fraction before reduction
    if (cmd.take_first) begin
      num_r     <= WW'(n1_mag_r);
      num_neg_r <= n1_neg_r;
      den_r     <= WW'(d1_mag_r);
      den_neg_r <= d1_neg_r;
    end else if (cmd.sum) begin
      num_r     <= sum_mag;
      num_neg_r <= sum_neg;
      den_neg_r <= d1_neg_r ^ d2_neg_r;
    end

    // Binary GCD: strip common twos into gk, then subtract odd values
    if (cmd.gcd_init) begin
      ga_r <= num_r;
      gb_r <= den_r;
      gk_r <= '0;
    end else if (cmd.gcd_step) begin
      if (!ga_r[0] && !gb_r[0]) begin
        ga_r <= ga_r >> 1;
        gb_r <= gb_r >> 1;
        gk_r <= gk_r + 1'b1;
      end else if (!ga_r[0]) begin
        ga_r <= ga_r >> 1;
      end else if (!gb_r[0]) begin
        gb_r <= gb_r >> 1;
      end else if (ga_r >= gb_r) begin
        ga_r <= ga_r - gb_r;
      end else begin
        gb_r <= gb_r - ga_r;
      end
    end

    // Divide numerator and denominator by the GCD
    if (cmd.div_init) begin
      dv_r <= (ga_r | gb_r) << gk_r;
      qn_r <= num_r;
      rn_r <= '0;
      qd_r <= den_r;
      rd_r <= '0;
    end else if (cmd.div_step) begin
      rn_r <= gen ? tn_sub[WW-1:0] : tn[WW-1:0];
      rd_r <= ged ? td_sub[WW-1:0] : td[WW-1:0];
      qn_r <= {qn_r[WW-2:0], gen};
      qd_r <= {qd_r[WW-2:0], ged};
    end

    // Result word
    if (cmd.out_load) begin
      if (sts.den_err) begin
        o_neg_r  <= 1'b0;
        o_num_r  <= '0;
        o_den_r  <= '0;
        o_zero_r <= 1'b0;
        o_err_r  <= 1'b1;
      end else if (sts.num_zero) begin
        o_neg_r  <= 1'b0;
        o_num_r  <= '0;
        o_den_r  <= DEN_OUT_W'(1);
        o_zero_r <= 1'b1;
        o_err_r  <= 1'b0;
      end else begin
        o_neg_r  <= num_neg_r ^ den_neg_r;
        o_num_r  <= NUM_OUT_W'(qn_r);
        o_den_r  <= DEN_OUT_W'(qd_r);
        o_zero_r <= 1'b0;
        o_err_r  <= 1'b0;
      end
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      o_valid_r <= 1'b1;
    end else if (out_tready) begin
      o_valid_r <= 1'b0;
    end
  end

  assign out_tvalid    = o_valid_r;
  assign is_negative   = o_neg_r;
  assign num_magnitude = o_num_r;
  assign den_value     = o_den_r;
  assign is_zero       = o_zero_r;
  assign den_error     = o_err_r;

endmodule

@@ rtl/fraction_add_sub_reduce_unit.sv @@
// Top level of the fraction add/subtract/reduce unit.
//
// Takes one word at a time: a request (reduce, add, subtract) and two signed fractions, and
// returns the reduced result as sign, numerator magnitude and positive denominator. Add and
// subtract form both cross products and the denominator product, sum the cross products,
// then, like reduce, run the binary GCD loop at one step per cycle and divide both terms by
// the GCD. The products come from one shift-add multiplier at one bit per cycle, and both
// quotients come from a pair of restoring dividers that retire one bit per cycle.
// Zero denominators return a word with only den_error set, and a zero numerator skips the
// GCD loop and the dividers. A finished word sits in an output register, so the next request is
// taken while it waits; a new request is taken only once the previous one has been handed to
// that register.
module fraction_add_sub_reduce_unit #(
  parameter int IN_WIDTH = fasr_pkg::IN_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input words
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // first_num, first_den, second_num, second_den (lowest first), zero padded
  input  logic [((4*IN_WIDTH+7)/8)*8-1:0]       in_tdata,
  // req_type
  input  logic [fasr_pkg::REQ_W-1:0]            in_tuser,
  // Result words
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // is_negative, num_magnitude, den_value (lowest first)
  output logic [fasr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // is_zero, den_error (lowest first)
  output logic [fasr_pkg::OUT_TUSER_W-1:0]      out_tuser
);
  import fasr_pkg::*;

  localparam int W = IN_WIDTH;

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic                 is_negative, is_zero, den_error;
  logic [NUM_OUT_W-1:0] num_magnitude;
  logic [DEN_OUT_W-1:0] den_value;

  fasr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fasr_dp #(
    .IN_WIDTH (IN_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (in_tuser),
    .first_num     ($signed(in_tdata[W-1:0])),
    .first_den     ($signed(in_tdata[2*W-1:W])),
    .second_num    ($signed(in_tdata[3*W-1:2*W])),
    .second_den    ($signed(in_tdata[4*W-1:3*W])),
    .is_negative   (is_negative),
    .num_magnitude (num_magnitude),
    .den_value     (den_value),
    .is_zero       (is_zero),
    .den_error     (den_error),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready)
  );

  // Pack the result word
  assign out_tdata = {den_value, num_magnitude, is_negative};
  assign out_tuser = {den_error, is_zero};

endmodule

@@ rtl/fasr_checker.sv @@
// Port-level checks for the fraction add/subtract/reduce unit, bound to the top level.
module fasr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [fasr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [fasr_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import fasr_pkg::*;

  // A stalled result word stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed or dropped while stalled");

  // One item at a time: ready drops right after a word is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  // An error word carries nothing else
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0 && !out_tuser[0])
    else $error("error word with nonzero payload");

  // A zero result is +0/1
  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[NUM_OUT_W:0] == '0 &&
      out_tdata[OUT_TDATA_W-1:NUM_OUT_W+1] == DEN_OUT_W'(1))
    else $error("zero result not encoded as 0/1");

endmodule

bind fraction_add_sub_reduce_unit fasr_checker u_fasr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/sv/fraction_add_sub_reduce_unit_test.sv @@
// Self-checking testbench for the fraction add/subtract/reduce unit.
module fraction_add_sub_reduce_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fasr_pkg::*;

  localparam int IN_W = IN_WIDTH_DEF;
  localparam int IN_TDATA_W = ((4 * IN_W + 7) / 8) * 8;

  // Spare operation code, handled as reduce
  localparam logic [REQ_W-1:0] OP_SPARE = 2'd3;

  // Run length limits, in clock cycles
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 600;

  // One request: operation and two fractions
  typedef struct {
    logic [REQ_W-1:0] op;
    logic [IN_W-1:0]  n1;
    logic [IN_W-1:0]  d1;
    logic [IN_W-1:0]  n2;
    logic [IN_W-1:0]  d2;
  } fraction_req_t;

  // Result word, laid out as {out_tuser, out_tdata}
  typedef struct packed {
    logic                 err;
    logic                 zero;
    logic [DEN_OUT_W-1:0] den;
    logic [NUM_OUT_W-1:0] mag;
    logic                 neg;
  } frac_result_t;

  // Exact sign-magnitude value
  typedef struct {
    bit              neg;
    longint unsigned mag;
  } signed_mag_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [REQ_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  frac_result_t pending_results[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  bit           idling_on = 1'b1;
  bit           hold_request = 1'b0;
  int           hold_left = 0;

  fraction_add_sub_reduce_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Two's complement operand to sign and magnitude
  function automatic signed_mag_t to_signed_mag(input logic [IN_W-1:0] raw);
    signed_mag_t v;
    v.neg = raw[IN_W-1];
    v.mag = v.neg ? ((64'd1 << IN_W) - 64'(raw)) : 64'(raw);
    return v;
  endfunction

  function automatic signed_mag_t sm_product(input signed_mag_t x, input signed_mag_t y);
    signed_mag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (x.neg != y.neg) && (r.mag != 0);
    return r;
  endfunction

  // Expected result word for one request
  function automatic frac_result_t predict_fraction(input fraction_req_t r);
    signed_mag_t     n1, d1, n2, d2, p, q, num, den;
    longint unsigned a, b, t;
    frac_result_t    res;
    n1 = to_signed_mag(r.n1);
    d1 = to_signed_mag(r.d1);
    n2 = to_signed_mag(r.n2);
    d2 = to_signed_mag(r.d2);
    res = '0;
    if (r.op == OP_ADD || r.op == OP_SUB) begin
      if (d1.mag == 0 || d2.mag == 0) begin
        res.err = 1'b1;
        return res;
      end
      p = sm_product(n1, d2);
      q = sm_product(n2, d1);
      if (r.op == OP_SUB && q.mag != 0) q.neg = !q.neg;
      // signed sum of the cross products
      if (p.neg == q.neg) begin
        num.mag = p.mag + q.mag;
        num.neg = p.neg;
      end else if (p.mag >= q.mag) begin
        num.mag = p.mag - q.mag;
        num.neg = p.neg;
      end else begin
        num.mag = q.mag - p.mag;
        num.neg = q.neg;
      end
      den = sm_product(d1, d2);
    end else begin
      // reduce, and the spare code too
      if (d1.mag == 0) begin
        res.err = 1'b1;
        return res;
      end
      num = n1;
      den = d1;
    end
    if (num.mag == 0) begin
      res.den  = DEN_OUT_W'(1);
      res.zero = 1'b1;
      return res;
    end
    // Euclid on the magnitudes
    a = num.mag;
    b = den.mag;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    res.neg = num.neg != den.neg;
    res.mag = NUM_OUT_W'(num.mag / a);
    res.den = DEN_OUT_W'(den.mag / a);
    return res;
  endfunction

  // Offer one word, wait for it to be taken, then queue its expected result
  task automatic send_fraction(input logic [REQ_W-1:0] op, input logic [IN_W-1:0] n1,
                               input logic [IN_W-1:0] d1, input logic [IN_W-1:0] n2,
                               input logic [IN_W-1:0] d2);
    fraction_req_t req;
    req.op = op;
    req.n1 = n1;
    req.d1 = d1;
    req.n2 = n2;
    req.d2 = d2;
    while (idling_on && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {d2, n2, d1, n1};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_fraction(req));
  endtask

  // Operand mix: full range, small values, edge values, values with common factors
  function automatic logic [IN_W-1:0] pick_operand();
    int mode;
    int v;
    mode = $urandom_range(99);
    if (mode < 45) begin
      v = $urandom();
    end else if (mode < 75) begin
      v = int'($urandom_range(80)) - 40;
    end else if (mode < 85) begin
      case ($urandom_range(4))
        0: v = -32768;
        1: v = 32767;
        2: v = -1;
        3: v = 1;
        default: v = 0;
      endcase
    end else begin
      v = int'($urandom_range(1, 180) * $urandom_range(1, 180));
      if ($urandom_range(1)) v = -v;
    end
    return IN_W'(v);
  endfunction

  task automatic run_random(input int count);
    logic [REQ_W-1:0] op;
    logic [IN_W-1:0]  n1, d1, n2, d2;
    int               pick;
    repeat (count) begin
      pick = $urandom_range(99);
      op = (pick < 30) ? OP_REDUCE : (pick < 62) ? OP_ADD : (pick < 94) ? OP_SUB : OP_SPARE;
      n1 = pick_operand();
      d1 = pick_operand();
      n2 = pick_operand();
      d2 = pick_operand();
      // now and then steer toward a zero result
      if ($urandom_range(19) == 0) begin
        d2 = d1;
        n2 = (op == OP_ADD) ? -n1 : n1;
      end
      send_fraction(op, n1, d1, n2, d2);
    end
  endtask

  // Edge values, every operation, zero results, zero denominators, spare code
  task automatic test_directed_cases();
    idling_on = 1'b1;
    send_fraction(OP_REDUCE, 16'sd0, 16'sd1, 16'sd0, 16'sd0);
    send_fraction(OP_REDUCE, 16'sd0, -16'sd5, 16'sd3, 16'sd7);
    send_fraction(OP_REDUCE, 16'sd6, -16'sd4, 16'hFFFF, 16'hFFFF);
    send_fraction(OP_REDUCE, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_fraction(OP_REDUCE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_fraction(OP_REDUCE, 16'h8000, 16'sd1, 16'sd0, 16'sd0);
    send_fraction(OP_REDUCE, 16'sd5, 16'sd0, 16'sd2, 16'sd0);
    send_fraction(OP_REDUCE, 16'sd0, 16'sd0, 16'sd1, 16'sd1);
    send_fraction(OP_SPARE, 16'sd12, 16'sd18, 16'sd1, 16'sd0);
    send_fraction(OP_SPARE, 16'sd3, 16'sd0, 16'sd1, 16'sd1);
    send_fraction(OP_ADD, 16'sd1, 16'sd2, -16'sd1, 16'sd2);
    send_fraction(OP_SUB, 16'sd3, 16'sd4, 16'sd3, 16'sd4);
    send_fraction(OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd2);
    send_fraction(OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd0);
    send_fraction(OP_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_fraction(OP_ADD, 16'sd1, 16'h7FFF, 16'sd1, 16'h8000);
    send_fraction(OP_SUB, 16'h8000, 16'sd1, 16'h7FFF, 16'sd1);
    send_fraction(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_fraction(OP_SUB, 16'h7FFF, 16'sd32766, 16'h8000, 16'sd32765);
    send_fraction(OP_ADD, 16'sd1, -16'sd1, 16'sd1, -16'sd1);
    send_fraction(OP_SUB, -16'sd1, -16'sd1, 16'sd1, 16'sd1);
    send_fraction(OP_ADD, 16'sd0, 16'sd7, 16'sd0, -16'sd3);
    send_fraction(OP_ADD, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
  endtask

  // Back-to-back words with no idling on either side
  task automatic test_steady_stream();
    idling_on = 1'b0;
    run_random(200);
    idling_on = 1'b1;
  endtask

  // Receiver holds off long enough for the unit to fill and stall its input
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    run_random(30);
  endtask

  task automatic test_random_mix();
    idling_on = 1'b1;
    run_random(800);
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    frac_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      if (pending_results.size() == 0) begin
        $display("%0t: result word %h with nothing expected", $time, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected neg=%0d mag=%0d den=%0d zero=%0d err=%0d",
                   $time, want.neg, want.mag, want.den, want.zero, want.err);
          $display("%0t:          actual   neg=%0d mag=%0d den=%0d zero=%0d err=%0d",
                   $time, got.neg, got.mag, got.den, got.zero, got.err);
          fail_count++;
        end
      end
    end
  end

  // Receiver ready: random idling plus the long hold-off when requested
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) hold_left--;
    out_tready <= (hold_left == 0) && !(idling_on && $urandom_range(99) < 24);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_steady_stream();
    test_output_backpressure();
    test_random_mix();
    in_tvalid <= 1'b0;
    // wait for the last results, then a while longer for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
